### sv/i2cram_pkg.sv
`default_nettype none
package i2cram_pkg;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_RD_BYTE = 2'd1,
        OP_WR_BYTE = 2'd2,
        OP_RD_WORD = 2'd3
    } op_t;

    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_PHASE_TICKS    = 2'd1;
    localparam logic [1:0] CFG_ACK_POLL_LIMIT = 2'd2;

    localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd104;
    localparam logic [15:0] PHASE_TICKS_RST    = 16'd1;
    localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd250;

    // item as classified by the front end
    typedef struct packed {
        logic       is_tick;
        op_t        op;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_level;
    } item_t;

    typedef struct packed {
        logic        ack_error;
        logic [15:0] read_value;
        logic        done_res;
        logic        busy_res;
        logic        sda_release;
        logic        scl_release;
    } result_t;

endpackage
`default_nettype wire

### sv/i2cram_front.sv
`default_nettype none
module i2cram_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [23:0]         s_tdata,
    input  wire logic [1:0]          s_tuser,
    input  wire logic                pop,
    output logic                     item_valid,
    output i2cram_pkg::item_t        item
);
    import i2cram_pkg::*;

    localparam int DEPTH = 2;

    item_t      queue_mem [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      in_item;
    logic       push;
    logic       do_pop;

    always_comb
    begin
        in_item.op          = op_t'(s_tuser);
        in_item.is_tick     = (op_t'(s_tuser) == OP_TICK);
        in_item.reg_addr    = s_tdata[7:0];
        in_item.write_data  = s_tdata[15:8];
        in_item.sda_level   = s_tdata[16];
    end

    assign s_tready   = (count_reg != 2'(DEPTH));
    assign item_valid = (count_reg != 2'd0);
    assign item       = queue_mem[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign do_pop     = pop && item_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### sv/i2cram_back.sv
`default_nettype none
module i2cram_back #(
    parameter int TICK_COUNT_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                item_valid,
    input  wire i2cram_pkg::item_t   item,
    output logic                     pop,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output i2cram_pkg::result_t      res
);
    import i2cram_pkg::*;

    localparam int CW = ((TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16) + 1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START1, PH_ADDR_W, PH_ACK1, PH_REG, PH_ACK2, PH_DATA,
        PH_ACK3, PH_START2, PH_ADDR_R, PH_ACK4, PH_READ, PH_NACK, PH_STOP
    } phase_t;

    logic [6:0]  dev_addr_reg;
    logic [15:0] phase_ticks_reg;
    logic [7:0]  poll_limit_reg;

    phase_t                     phase_reg, phase_next;
    logic [1:0]                 quarter_reg, quarter_next;
    logic [2:0]                 bit_reg, bit_next;
    logic [7:0]                 shift_reg, shift_next;
    logic [7:0]                 poll_reg, poll_next;
    logic [TICK_COUNT_BITS-1:0] tick_reg, tick_next;
    op_t                        pend_op_reg, pend_op_next;
    logic [7:0]                 lreg_reg, lreg_next;
    logic [7:0]                 ldata_reg, ldata_next;
    logic [15:0]                word_reg, word_next;
    logic                       second_reg, second_next;
    logic                       err_reg, err_next;
    logic                       res_valid_reg, res_valid_next;
    result_t                    res_reg, res_next;

    logic        done;
    logic        do_enter;
    phase_t      enter_phase;
    logic [7:0]  enter_byte;
    logic [15:0] limit;
    logic [CW-1:0] tick_inc;
    logic [CW-1:0] limit_ext;
    logic        is_ack;
    logic        is_shift;
    logic        scl, sda;

    assign pop       = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign limit     = (phase_ticks_reg == 16'd0) ? 16'd1 : phase_ticks_reg;
    assign tick_inc  = {{(CW - TICK_COUNT_BITS){1'b0}}, tick_reg} + CW'(1);
    assign limit_ext = {{(CW - 16){1'b0}}, limit};
    assign is_ack    = (phase_reg == PH_ACK1) || (phase_reg == PH_ACK2) ||
                       (phase_reg == PH_ACK3) || (phase_reg == PH_ACK4);
    assign is_shift  = (phase_reg == PH_ADDR_W) || (phase_reg == PH_REG) ||
                       (phase_reg == PH_DATA) || (phase_reg == PH_ADDR_R) ||
                       (phase_reg == PH_READ);

    always_comb
    begin
        phase_next   = phase_reg;
        quarter_next = quarter_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        poll_next    = poll_reg;
        tick_next    = tick_reg;
        pend_op_next = pend_op_reg;
        lreg_next    = lreg_reg;
        ldata_next   = ldata_reg;
        word_next    = word_reg;
        second_next  = second_reg;
        err_next     = err_reg;
        done         = 1'b0;
        do_enter     = 1'b0;
        enter_phase  = PH_IDLE;
        enter_byte   = 8'd0;

        if (item.is_tick)
        begin
            if (phase_reg != PH_IDLE)
            begin
                if (is_ack && quarter_reg == 2'd2)
                begin
                    // acknowledge poll: once per tick, no divider
                    if (!item.sda_level)
                    begin
                        quarter_next = 2'd3;
                        tick_next    = '0;
                    end
                    else if (poll_reg >= poll_limit_reg)
                    begin
                        err_next     = 1'b1;
                        quarter_next = 2'd3;
                        tick_next    = '0;
                    end
                    else
                    begin
                        poll_next = poll_reg + 8'd1;
                    end
                end
                else if (tick_inc < limit_ext && !(&tick_reg))
                begin
                    tick_next = tick_reg + TICK_COUNT_BITS'(1);
                end
                else
                begin
                    tick_next = '0;
                    if (quarter_reg == 2'd3)
                    begin
                        if (is_shift && bit_reg != 3'd7)
                        begin
                            bit_next     = bit_reg + 3'd1;
                            quarter_next = 2'd0;
                            if (phase_reg != PH_READ)
                            begin
                                shift_next = {shift_reg[6:0], 1'b0};
                            end
                        end
                        else if (is_ack && err_reg)
                        begin
                            do_enter    = 1'b1;
                            enter_phase = PH_STOP;
                        end
                        else
                        begin
                            do_enter = 1'b1;
                            unique case (phase_reg)
                                PH_START1:
                                begin
                                    enter_phase = PH_ADDR_W;
                                    enter_byte  = {dev_addr_reg, 1'b0};
                                end
                                PH_ADDR_W: enter_phase = PH_ACK1;
                                PH_ACK1:
                                begin
                                    enter_phase = PH_REG;
                                    enter_byte  = lreg_reg;
                                end
                                PH_REG:    enter_phase = PH_ACK2;
                                PH_ACK2:
                                begin
                                    if (pend_op_reg == OP_WR_BYTE)
                                    begin
                                        enter_phase = PH_DATA;
                                        enter_byte  = ldata_reg;
                                    end
                                    else
                                    begin
                                        enter_phase = PH_START2;
                                    end
                                end
                                PH_DATA:   enter_phase = PH_ACK3;
                                PH_ACK3:   enter_phase = PH_STOP;
                                PH_START2:
                                begin
                                    enter_phase = PH_ADDR_R;
                                    enter_byte  = {dev_addr_reg, 1'b1};
                                end
                                PH_ADDR_R: enter_phase = PH_ACK4;
                                PH_ACK4:   enter_phase = PH_READ;
                                PH_READ:
                                begin
                                    word_next   = {word_reg[7:0], shift_reg};
                                    enter_phase = PH_NACK;
                                end
                                PH_NACK:   enter_phase = PH_STOP;
                                PH_STOP:
                                begin
                                    // word read: run the second byte at reg + 1
                                    if (pend_op_reg == OP_RD_WORD && !second_reg && !err_reg)
                                    begin
                                        second_next = 1'b1;
                                        lreg_next   = lreg_reg + 8'd1;
                                        enter_phase = PH_START1;
                                    end
                                    else
                                    begin
                                        enter_phase = PH_IDLE;
                                        done        = 1'b1;
                                    end
                                end
                                default:   enter_phase = PH_IDLE;
                            endcase
                        end
                    end
                    else
                    begin
                        if (phase_reg == PH_READ && quarter_reg == 2'd1)
                        begin
                            shift_next = {shift_reg[6:0], item.sda_level};
                        end
                        quarter_next = quarter_reg + 2'd1;
                        if (quarter_reg == 2'd1)
                        begin
                            poll_next = 8'd0;
                        end
                    end
                end
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            pend_op_next = item.op;
            lreg_next    = item.reg_addr;
            ldata_next   = item.write_data;
            word_next    = 16'd0;
            second_next  = 1'b0;
            err_next     = 1'b0;
            poll_next    = 8'd0;
            tick_next    = '0;
            do_enter     = 1'b1;
            enter_phase  = PH_START1;
        end

        if (do_enter)
        begin
            phase_next   = enter_phase;
            quarter_next = 2'd0;
            bit_next     = 3'd0;
            shift_next   = enter_byte;
        end

        if (phase_next == PH_STOP)
        begin
            scl = (quarter_next != 2'd0);
        end
        else
        begin
            scl = (quarter_next == 2'd1) || (quarter_next == 2'd2);
        end
        unique case (phase_next)
            PH_IDLE:                 sda = 1'b1;
            PH_START1, PH_START2:    sda = (quarter_next < 2'd2);
            PH_ADDR_W, PH_REG, PH_DATA, PH_ADDR_R:
                                     sda = shift_next[7];
            PH_STOP:                 sda = (quarter_next >= 2'd2);
            default:                 sda = 1'b1;
        endcase

        res_next.scl_release = (phase_next == PH_IDLE) ? 1'b1 : scl;
        res_next.sda_release = sda;
        res_next.busy_res    = (phase_next != PH_IDLE);
        res_next.done_res    = done;
        res_next.read_value  = (done && !err_next && pend_op_next != OP_WR_BYTE) ?
                               word_next : 16'd0;
        res_next.ack_error   = err_next;

        res_valid_next = pop ? 1'b1 : (res_valid_reg && !res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= DEVICE_ADDRESS_RST;
            phase_ticks_reg <= PHASE_TICKS_RST;
            poll_limit_reg  <= ACK_POLL_LIMIT_RST;
            phase_reg       <= PH_IDLE;
            quarter_reg     <= 2'd0;
            bit_reg         <= 3'd0;
            shift_reg       <= 8'd0;
            poll_reg        <= 8'd0;
            tick_reg        <= '0;
            pend_op_reg     <= OP_TICK;
            lreg_reg        <= 8'd0;
            ldata_reg       <= 8'd0;
            word_reg        <= 16'd0;
            second_reg      <= 1'b0;
            err_reg         <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_data[6:0];
                    CFG_PHASE_TICKS:    phase_ticks_reg <= cfg_data;
                    CFG_ACK_POLL_LIMIT: poll_limit_reg  <= cfg_data[7:0];
                    default:            ;
                endcase
            end
            if (pop)
            begin
                phase_reg   <= phase_next;
                quarter_reg <= quarter_next;
                bit_reg     <= bit_next;
                shift_reg   <= shift_next;
                poll_reg    <= poll_next;
                tick_reg    <= tick_next;
                pend_op_reg <= pend_op_next;
                lreg_reg    <= lreg_next;
                ldata_reg   <= ldata_next;
                word_reg    <= word_next;
                second_reg  <= second_next;
                err_reg     <= err_next;
                res_reg     <= res_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

endmodule
`default_nettype wire

### sv/i2c_register_access_master_unit.sv
// Path: an accepted item passes through a queue slot, then the result register.
// Throughput: one item per cycle; the sequencer steps once per item popped from the
// two-entry queue, and input stalls only once both queue slots and the result register are full.
// Reset: asynchronous, active low; sequencer idle and result register cleared, registers at
// their defaults (address 104, one tick per quarter, poll limit 250), queue empty.
`default_nettype none
module i2c_register_access_master_unit #(
    parameter int TICK_COUNT_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // reg_addr[7:0], write_data[15:8], sda_level[16]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // scl_release[0], sda_release[1], busy_res[2],
                                        // done_res[3], read_value[19:4], ack_error[20]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import i2cram_pkg::*;

    item_t   item;
    logic    item_valid;
    logic    pop;
    result_t res;

    assign cfg_ready = 1'b1;

    i2cram_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cram_back #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {3'b000, res.ack_error, res.read_value, res.done_res,
                      res.busy_res, res.sda_release, res.scl_release};

endmodule
`default_nettype wire

### dv/i2c_register_access_master_unit_tb.sv
`timescale 1ns / 1ps
module i2c_register_access_master_unit_tb;
    import i2cram_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [1:0]  CFG_UNMAPPED = 2'd3;

    // bus elements of the sequencer
    typedef enum logic [3:0] {
        EL_IDLE,
        EL_START,
        EL_ADDR_WR,
        EL_ACK_ADDR_WR,
        EL_REG,
        EL_ACK_REG,
        EL_DATA,
        EL_ACK_DATA,
        EL_RESTART,
        EL_ADDR_RD,
        EL_ACK_ADDR_RD,
        EL_READ,
        EL_NACK,
        EL_STOP
    } bus_el_t;

    typedef struct packed {
        logic [6:0]  dev_addr;
        logic [15:0] quarter_ticks;
        logic [7:0]  poll_limit;
        bus_el_t     el;
        logic [1:0]  quarter;
        logic [3:0]  bit_cnt;
        logic [7:0]  shreg;
        logic [7:0]  polls;
        logic [15:0] ticks;
        op_t         op;
        logic [7:0]  reg_a;
        logic [7:0]  wdata;
        logic [15:0] word;
        logic        second;
        logic        err;
    } seq_state_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] reg_a;
        logic [7:0] wdata;
        logic       sda;
    } bus_item_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = OP_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    seq_state_t  dut_mirror;   // advanced on accepted transfers
    seq_state_t  plan_mirror;  // advanced as stimulus is generated
    bus_item_t   queued_items[$];
    result_t     predicted_out[$];

    int          items_queued    = 0;
    int          items_sent      = 0;
    int          results_checked = 0;
    int          fail_count      = 0;
    int          trans_ended     = 0;
    int          trans_aborted   = 0;
    int unsigned cycle_cnt       = 0;
    logic        no_idle         = 1'b0;
    logic        long_hold_done  = 1'b0;
    logic [3:0]  src_gap         = '0;
    logic [3:0]  sink_stall      = '0;
    logic [7:0]  hold_left       = '0;

    i2c_register_access_master_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic seq_state_t seq_reset();
        seq_state_t st;
        st               = '0;
        st.dev_addr      = DEVICE_ADDRESS_RST;
        st.quarter_ticks = PHASE_TICKS_RST;
        st.poll_limit    = ACK_POLL_LIMIT_RST;
        st.el            = EL_IDLE;
        st.op            = OP_TICK;
        return st;
    endfunction

    function automatic void apply_reg(inout seq_state_t st, input logic [1:0] idx,
                                      input logic [15:0] val);
        case (idx)
            CFG_DEVICE_ADDRESS: st.dev_addr = val[6:0];
            CFG_PHASE_TICKS:    st.quarter_ticks = val;
            CFG_ACK_POLL_LIMIT: st.poll_limit = val[7:0];
            default: ;
        endcase
    endfunction

    function automatic logic is_ack_el(input bus_el_t el);
        return el == EL_ACK_ADDR_WR || el == EL_ACK_REG || el == EL_ACK_DATA ||
               el == EL_ACK_ADDR_RD;
    endfunction

    function automatic void enter_el(inout seq_state_t st, input bus_el_t el,
                                     input logic [7:0] b);
        st.el      = el;
        st.quarter = 2'd0;
        st.bit_cnt = 4'd0;
        st.shreg   = b;
    endfunction

    // end of quarter 3; returns 1 when the whole transaction is over
    function automatic logic end_element(inout seq_state_t st);
        if ((st.el == EL_ADDR_WR || st.el == EL_REG || st.el == EL_DATA ||
             st.el == EL_ADDR_RD || st.el == EL_READ) && st.bit_cnt < 4'd7)
        begin
            st.bit_cnt = st.bit_cnt + 4'd1;
            st.quarter = 2'd0;
            if (st.el != EL_READ)
                st.shreg = {st.shreg[6:0], 1'b0};
            return 1'b0;
        end
        if (is_ack_el(st.el) && st.err)
        begin
            enter_el(st, EL_STOP, 8'h00);
            return 1'b0;
        end
        case (st.el)
            EL_START:       enter_el(st, EL_ADDR_WR, {st.dev_addr, 1'b0});
            EL_ADDR_WR:     enter_el(st, EL_ACK_ADDR_WR, 8'h00);
            EL_ACK_ADDR_WR: enter_el(st, EL_REG, st.reg_a);
            EL_REG:         enter_el(st, EL_ACK_REG, 8'h00);
            EL_ACK_REG:
            begin
                if (st.op == OP_WR_BYTE)
                    enter_el(st, EL_DATA, st.wdata);
                else
                    enter_el(st, EL_RESTART, 8'h00);
            end
            EL_DATA:        enter_el(st, EL_ACK_DATA, 8'h00);
            EL_ACK_DATA:    enter_el(st, EL_STOP, 8'h00);
            EL_RESTART:     enter_el(st, EL_ADDR_RD, {st.dev_addr, 1'b1});
            EL_ADDR_RD:     enter_el(st, EL_ACK_ADDR_RD, 8'h00);
            EL_ACK_ADDR_RD: enter_el(st, EL_READ, 8'h00);
            EL_READ:
            begin
                st.word = {st.word[7:0], st.shreg};
                enter_el(st, EL_NACK, 8'h00);
            end
            EL_NACK:        enter_el(st, EL_STOP, 8'h00);
            default:
            begin
                // word read: second pass at the next register
                if (st.op == OP_RD_WORD && !st.second && !st.err)
                begin
                    st.second = 1'b1;
                    st.reg_a  = st.reg_a + 8'd1;
                    enter_el(st, EL_START, 8'h00);
                    return 1'b0;
                end
                enter_el(st, EL_IDLE, 8'h00);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic bus_tick(inout seq_state_t st, input logic sda);
        logic [16:0] span;
        span = (st.quarter_ticks == 16'd0) ? 17'd1 : {1'b0, st.quarter_ticks};
        // acknowledge polling runs once per tick, without the divider
        if (is_ack_el(st.el) && st.quarter == 2'd2)
        begin
            if (!sda)
            begin
                st.quarter = 2'd3;
                st.ticks   = 16'd0;
            end
            else if ({1'b0, st.polls} + 9'd1 > {1'b0, st.poll_limit})
            begin
                st.err     = 1'b1;
                st.quarter = 2'd3;
                st.ticks   = 16'd0;
            end
            else
                st.polls = st.polls + 8'd1;
            return 1'b0;
        end
        if ({1'b0, st.ticks} + 17'd1 < span && st.ticks != 16'hFFFF)
        begin
            st.ticks = st.ticks + 16'd1;
            return 1'b0;
        end
        st.ticks = 16'd0;
        if (st.quarter == 2'd3)
            return end_element(st);
        if (st.el == EL_READ && st.quarter == 2'd1)
            st.shreg = {st.shreg[6:0], sda};
        st.quarter = st.quarter + 2'd1;
        if (st.quarter == 2'd2)
            st.polls = 8'd0;
        return 1'b0;
    endfunction

    function automatic void i2c_seq_step(inout seq_state_t st, input op_t op,
                                         input logic [7:0] ra, input logic [7:0] wd,
                                         input logic sda, output result_t res);
        logic fin;
        logic scl_l;
        logic sda_l;
        fin = 1'b0;
        if (op == OP_TICK)
        begin
            if (st.el != EL_IDLE)
                fin = bus_tick(st, sda);
        end
        else if (st.el == EL_IDLE)
        begin
            st.op     = op;
            st.reg_a  = ra;
            st.wdata  = wd;
            st.word   = 16'd0;
            st.second = 1'b0;
            st.err    = 1'b0;
            st.polls  = 8'd0;
            st.ticks  = 16'd0;
            enter_el(st, EL_START, 8'h00);
        end
        if (st.el == EL_IDLE)
        begin
            scl_l = 1'b1;
            sda_l = 1'b1;
        end
        else
        begin
            if (st.el == EL_STOP)
                scl_l = (st.quarter != 2'd0);
            else
                scl_l = (st.quarter == 2'd1 || st.quarter == 2'd2);
            case (st.el)
                EL_START, EL_RESTART:                    sda_l = (st.quarter < 2'd2);
                EL_ADDR_WR, EL_REG, EL_DATA, EL_ADDR_RD: sda_l = st.shreg[7];
                EL_STOP:                                 sda_l = (st.quarter >= 2'd2);
                default:                                 sda_l = 1'b1;
            endcase
        end
        res.scl_release = scl_l;
        res.sda_release = sda_l;
        res.busy_res    = (st.el != EL_IDLE);
        res.done_res    = fin;
        res.read_value  = (fin && !st.err && st.op != OP_WR_BYTE) ? st.word : 16'h0000;
        res.ack_error   = st.err;
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin : drv
        bus_item_t nxt;
        result_t   res;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_TICK;
            src_gap  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                i2c_seq_step(dut_mirror, op_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
                             s_tdata[16], res);
                predicted_out.push_back(res);
                items_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap != 4'd0)
                begin
                    s_tvalid <= 1'b0;
                    src_gap  <= src_gap - 4'd1;
                end
                else if (queued_items.size() != 0)
                begin
                    nxt      = queued_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= {7'd0, nxt.sda, nxt.wdata, nxt.reg_a};
                    if (!no_idle && $urandom_range(0, 9) == 0)
                        src_gap <= 4'($urandom_range(1, 14));
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_checked, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : mon
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            sink_stall <= '0;
            hold_left  <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[20:0];
                if (predicted_out.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d arrived with nothing predicted: 0x%0h",
                                 results_checked, m_tdata);
                end
                else
                begin
                    want = predicted_out.pop_front();
                    check_field("scl_release", 16'(want.scl_release), 16'(got.scl_release));
                    check_field("sda_release", 16'(want.sda_release), 16'(got.sda_release));
                    check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
                    check_field("done_res", 16'(want.done_res), 16'(got.done_res));
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("ack_error", 16'(want.ack_error), 16'(got.ack_error));
                    if (want.done_res)
                    begin
                        trans_ended++;
                        if (want.ack_error)
                            trans_aborted++;
                    end
                end
                results_checked++;
            end
            // one long hold so the input side backs up
            if (hold_left != 8'd0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 8'd1;
            end
            else if (!long_hold_done && results_checked >= 200)
            begin
                m_tready       <= 1'b0;
                hold_left      <= 8'd119;
                long_hold_done <= 1'b1;
            end
            else if (sink_stall != 4'd0)
            begin
                m_tready   <= 1'b0;
                sink_stall <= sink_stall - 4'd1;
            end
            else if (!no_idle && $urandom_range(0, 11) == 0)
            begin
                m_tready   <= 1'b0;
                sink_stall <= 4'($urandom_range(0, 13));
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push_item(input op_t op, input logic [7:0] ra, input logic [7:0] wd,
                             input logic sda);
        bus_item_t it;
        result_t   unused;
        it.op    = op;
        it.reg_a = ra;
        it.wdata = wd;
        it.sda   = sda;
        i2c_seq_step(plan_mirror, op, ra, wd, sda, unused);
        queued_items.push_back(it);
        items_queued++;
    endtask

    // command plus the ticks that carry it to its end; acks answered after a few
    // high polls, or never with probability miss_pct per acknowledge
    task automatic run_transaction(input op_t op, input logic [7:0] ra, input logic [7:0] wd,
                                   input int miss_pct, input int noise_pct);
        logic [9:0] ack_hold;
        logic       s;
        ack_hold = 10'd0;
        push_item(op, ra, wd, 1'($urandom_range(0, 1)));
        while (plan_mirror.el != EL_IDLE)
        begin
            if (noise_pct != 0 && $urandom_range(1, 100) <= noise_pct)
                push_item(op_t'(2'($urandom_range(1, 3))), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
            begin
                s = 1'($urandom_range(0, 1));
                if (is_ack_el(plan_mirror.el) && plan_mirror.quarter == 2'd2)
                begin
                    if (plan_mirror.polls == 8'd0)
                        ack_hold = ($urandom_range(1, 100) <= miss_pct) ? 10'd1000
                                 : 10'($urandom_range(0, 3));
                    s = ({2'b00, plan_mirror.polls} < ack_hold);
                end
                push_item(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), s);
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (items_sent != items_queued || predicted_out.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(dut_mirror, idx, val);
        apply_reg(plan_mirror, idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stim
        dut_mirror  = seq_reset();
        plan_mirror = seq_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset: idle ticks, then a word read whose second register
        // wraps to zero
        push_item(OP_TICK, 8'hFF, 8'hFF, 1'b0);
        push_item(OP_TICK, 8'h00, 8'h00, 1'b1);
        run_transaction(OP_RD_WORD, 8'hFF, 8'h00, 0, 2);
        wait_drained();

        // zero quarter length acts as one; zero poll limit fails on the first high poll
        write_reg(CFG_DEVICE_ADDRESS, 16'hFF7F);
        write_reg(CFG_PHASE_TICKS, 16'h0000);
        write_reg(CFG_ACK_POLL_LIMIT, 16'h0000);
        write_reg(CFG_UNMAPPED, 16'($urandom_range(0, 65535)));
        run_transaction(OP_RD_BYTE, 8'h80, 8'h7F, 100, 0);
        run_transaction(OP_WR_BYTE, 8'h00, 8'h00, 100, 0);
        wait_drained();

        write_reg(CFG_DEVICE_ADDRESS, 16'h0000);
        write_reg(CFG_PHASE_TICKS, 16'd2);
        write_reg(CFG_ACK_POLL_LIMIT, 16'($urandom_range(1, 6)));
        run_transaction(OP_RD_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        100, 3);
        wait_drained();

        no_idle <= 1'b1;
        write_reg(CFG_DEVICE_ADDRESS, 16'($urandom_range(0, 65535)));
        write_reg(CFG_PHASE_TICKS, 16'd1);
        write_reg(CFG_ACK_POLL_LIMIT, 16'($urandom_range(1, 4)));
        run_transaction(OP_WR_BYTE, 8'hFF, 8'hFF, 0, 3);
        run_transaction(OP_RD_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        0, 0);
        wait_drained();

        // longest quarter: the transaction is left running at the end
        write_reg(CFG_PHASE_TICKS, 16'hFFFF);
        push_item(OP_RD_WORD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
        repeat (20)
            push_item(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        wait_drained();
        repeat (10) @(posedge clk);

        if (predicted_out.size() != 0)
        begin
            $display("%0d predicted results never arrived", predicted_out.size());
            fail_count += predicted_out.size();
        end
        $display("Run: %0d items sent, %0d results checked, %0d transactions ended, %0d aborted",
                 items_sent, results_checked, trans_ended, trans_aborted);
        $display("Configs: addr 0/104/127/random, quarter 0..2 and 65535 ticks, poll limit 0..6/250");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
